/* sv/scmp_pkg.sv */
package scmp_pkg;

    typedef enum logic [1:0] {
        OP_SENSE   = 2'd0,
        OP_SELECT  = 2'd1,
        OP_PARAM   = 2'd2,
        OP_FEATURE = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        KIND_BYTE    = 2'd0,
        KIND_DONE    = 2'd1,
        KIND_REQUEST = 2'd2
    } kind_t;

    typedef enum logic [2:0] {
        SC_GOOD       = 3'd0,
        SC_BAD_BUFFER = 3'd1,
        SC_BAD_CDB    = 3'd2,
        SC_LIST_LEN   = 3'd3,
        SC_BAD_LIST   = 3'd4,
        SC_OVERRUN    = 3'd5,
        SC_MEDIUM     = 3'd6
    } status_t;

    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_LIST = 2'd1,
        PH_WAIT = 2'd2
    } phase_t;

    typedef enum logic {
        CS_IDLE   = 1'b0,
        CS_STREAM = 1'b1
    } ctrl_state_t;

    localparam logic [5:0] CACHING_PAGE = 6'h08;
    localparam logic [5:0] ALL_PAGES    = 6'h3F;
    localparam logic [7:0] CACHING_LEN  = 8'h12;
    localparam logic [7:0] WCE_MASK     = 8'h04;
    localparam logic [3:0] HDR_SHORT    = 4'd4;
    localparam logic [3:0] HDR_LONG     = 4'd8;
    localparam logic [4:0] PAGE_BYTES   = 5'd20;
    localparam logic       REG_CACHE_PRESENT = 1'b0;

    typedef struct packed {
        logic take;
        logic step;
        logic streaming;
    } cmd_t;

    typedef struct packed {
        logic out_free;
        logic start_stream;
        logic stream_end;
    } sts_t;

endpackage

/* sv/scmp_ctrl.sv */
module scmp_ctrl (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            s_valid,
    output logic            s_ready,
    input  scmp_pkg::sts_t  sts,
    output scmp_pkg::cmd_t  cmd
);

    scmp_pkg::ctrl_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= scmp_pkg::CS_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next    = state_reg;
        s_ready       = 1'b0;
        cmd.take      = 1'b0;
        cmd.step      = 1'b0;
        cmd.streaming = 1'b0;
        case (state_reg)
            scmp_pkg::CS_IDLE: begin
                s_ready  = sts.out_free;
                cmd.take = s_valid && sts.out_free;
                if (cmd.take && sts.start_stream) begin
                    state_next = scmp_pkg::CS_STREAM;
                end
            end
            scmp_pkg::CS_STREAM: begin
                cmd.streaming = 1'b1;
                cmd.step      = sts.out_free;
                if (sts.out_free && sts.stream_end) begin
                    state_next = scmp_pkg::CS_IDLE;
                end
            end
            default: begin
                state_next = scmp_pkg::CS_IDLE;
            end
        endcase
    end

endmodule

/* sv/scmp_dp.sv */
module scmp_dp (
    input  logic            aclk,
    input  logic            aresetn,
    input  scmp_pkg::cmd_t  cmd,
    output scmp_pkg::sts_t  sts,
    input  logic [1:0]      operation,
    input  logic            is_ten_byte,
    input  logic [5:0]      page_sel,
    input  logic [15:0]     length,
    input  logic            buffer_ok,
    input  logic [7:0]      data_byte,
    input  logic            feature_ok,
    input  logic            cache_present,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [1:0]      kind,
    output logic [7:0]      response_byte,
    output logic            last,
    output logic [2:0]      status,
    output logic [15:0]     actual_length,
    output logic            cache_request
);

    // result register
    logic        m_valid_reg, m_valid_next;
    logic [1:0]  kind_reg;
    logic [7:0]  byte_reg;
    logic        last_reg;
    logic [2:0]  status_reg;
    logic [15:0] actual_reg;
    logic        req_reg;

    // sense stream
    logic [4:0]  n_reg, n_next;
    logic [4:0]  idx_reg, idx_next;
    logic        zero_reg, zero_next;
    logic        ten_reg, ten_next;

    // select list walk
    scmp_pkg::phase_t  phase_reg, phase_next;
    scmp_pkg::status_t err_reg, err_next;
    logic        long_reg, long_next;
    logic [15:0] list_len_reg, list_len_next;
    logic [16:0] pos_reg, pos_next;
    logic [15:0] desc_reg, desc_next;
    logic [16:0] npo_reg, npo_next;
    logic [5:0]  code_reg, code_next;
    logic [16:0] cpos_reg, cpos_next;
    logic        plen_nz_reg, plen_nz_next;
    logic        saw_reg, saw_next;
    logic        newbit_reg, newbit_next;
    logic        wce_reg, wce_next;

    // combinational decode
    scmp_pkg::op_t op;
    logic [3:0]  hdr;
    logic        len_short;
    logic [15:0] room;
    logic [4:0]  used;
    logic [4:0]  total;
    logic        page_ok;
    logic [4:0]  stream_n;
    logic [3:0]  s_hdr;
    logic [4:0]  s_page;
    logic [7:0]  s_byte;
    logic [3:0]  b_hdr;
    logic [15:0] desc_full;
    logic [16:0] hdr_plus;
    logic [16:0] page_end;

    logic        out_load;
    logic [1:0]  o_kind;
    logic [7:0]  o_byte;
    logic        o_last;
    logic [2:0]  o_status;
    logic [15:0] o_actual;
    logic        o_req;

    assign op        = scmp_pkg::op_t'(operation);
    assign hdr       = is_ten_byte ? scmp_pkg::HDR_LONG : scmp_pkg::HDR_SHORT;
    assign len_short = length < {12'd0, hdr};
    assign room      = length - {12'd0, hdr};
    assign used      = (room < 16'(scmp_pkg::PAGE_BYTES)) ? room[4:0] : scmp_pkg::PAGE_BYTES;
    assign total     = {1'b0, hdr} + used;
    assign page_ok   = (page_sel == scmp_pkg::CACHING_PAGE)
                    || (page_sel == scmp_pkg::ALL_PAGES);
    assign stream_n  = len_short ? length[4:0] : total;

    assign sts.out_free     = !m_valid_reg || m_ready;
    assign sts.start_stream = (op == scmp_pkg::OP_SENSE) && buffer_ok && (len_short || page_ok);
    assign sts.stream_end   = idx_reg == n_reg;

    assign s_hdr  = ten_reg ? scmp_pkg::HDR_LONG : scmp_pkg::HDR_SHORT;
    assign s_page = idx_reg - {1'b0, s_hdr};

    always_comb begin
        s_byte = 8'd0;
        if (!zero_reg) begin
            if (idx_reg < {1'b0, s_hdr}) begin
                if (ten_reg) begin
                    if (idx_reg == 5'd1) begin
                        s_byte = {3'd0, n_reg - 5'd2};
                    end
                end else if (idx_reg == 5'd0) begin
                    s_byte = {3'd0, n_reg - 5'd1};
                end
            end else begin
                case (s_page)
                    5'd0:    s_byte = {2'd0, scmp_pkg::CACHING_PAGE};
                    5'd1:    s_byte = scmp_pkg::CACHING_LEN;
                    5'd2:    s_byte = wce_reg ? scmp_pkg::WCE_MASK : 8'd0;
                    default: s_byte = 8'd0;
                endcase
            end
        end
    end

    assign b_hdr     = long_reg ? scmp_pkg::HDR_LONG : scmp_pkg::HDR_SHORT;
    assign desc_full = long_reg ? {desc_reg[15:8], data_byte} : {8'd0, data_byte};
    assign hdr_plus  = 17'(b_hdr) + {1'b0, desc_full};
    assign page_end  = npo_reg + 17'd2 + 17'(data_byte);

    always_comb begin
        m_valid_next  = m_valid_reg;
        n_next        = n_reg;
        idx_next      = idx_reg;
        zero_next     = zero_reg;
        ten_next      = ten_reg;
        phase_next    = phase_reg;
        err_next      = err_reg;
        long_next     = long_reg;
        list_len_next = list_len_reg;
        pos_next      = pos_reg;
        desc_next     = desc_reg;
        npo_next      = npo_reg;
        code_next     = code_reg;
        cpos_next     = cpos_reg;
        plen_nz_next  = plen_nz_reg;
        saw_next      = saw_reg;
        newbit_next   = newbit_reg;
        wce_next      = wce_reg;
        out_load      = 1'b0;
        o_kind        = scmp_pkg::KIND_DONE;
        o_byte        = 8'd0;
        o_last        = 1'b1;
        o_status      = scmp_pkg::SC_GOOD;
        o_actual      = 16'd0;
        o_req         = 1'b0;

        if (cmd.take) begin
            case (op)
                scmp_pkg::OP_SENSE: begin
                    phase_next = scmp_pkg::PH_IDLE;
                    if (!buffer_ok) begin
                        out_load = 1'b1;
                        o_status = scmp_pkg::SC_BAD_BUFFER;
                    end else if (sts.start_stream) begin
                        n_next    = stream_n;
                        idx_next  = 5'd0;
                        zero_next = len_short;
                        ten_next  = is_ten_byte;
                    end else begin
                        out_load = 1'b1;
                        o_status = scmp_pkg::SC_BAD_CDB;
                    end
                end
                scmp_pkg::OP_SELECT: begin
                    phase_next = scmp_pkg::PH_IDLE;
                    if (length == 16'd0) begin
                        out_load = 1'b1;
                    end else if (!buffer_ok || len_short) begin
                        out_load = 1'b1;
                        o_status = scmp_pkg::SC_LIST_LEN;
                    end else begin
                        phase_next    = scmp_pkg::PH_LIST;
                        long_next     = is_ten_byte;
                        list_len_next = length;
                        pos_next      = 17'd0;
                        desc_next     = 16'd0;
                        npo_next      = 17'd0;
                        code_next     = 6'd0;
                        cpos_next     = 17'd0;
                        plen_nz_next  = 1'b0;
                        saw_next      = 1'b0;
                        newbit_next   = wce_reg;
                        err_next      = scmp_pkg::SC_GOOD;
                    end
                end
                scmp_pkg::OP_PARAM: begin
                    if (phase_reg == scmp_pkg::PH_LIST) begin
                        if (err_reg == scmp_pkg::SC_GOOD) begin
                            if (pos_reg < 17'(b_hdr)) begin
                                if (long_reg) begin
                                    if (pos_reg == 17'd6) begin
                                        desc_next = {data_byte, 8'd0};
                                    end else if (pos_reg == 17'd7) begin
                                        desc_next = desc_full;
                                    end
                                end else if (pos_reg == 17'd3) begin
                                    desc_next = desc_full;
                                end
                                if (pos_reg == 17'(b_hdr) - 17'd1) begin
                                    if (hdr_plus > {1'b0, list_len_reg}) begin
                                        err_next = scmp_pkg::SC_BAD_LIST;
                                    end else begin
                                        npo_next = hdr_plus;
                                    end
                                    plen_nz_next = 1'b0;
                                end
                            end else if (pos_reg == npo_reg) begin
                                code_next    = data_byte[5:0];
                                plen_nz_next = 1'b0;
                            end else if (pos_reg == npo_reg + 17'd1) begin
                                plen_nz_next = data_byte != 8'd0;
                                cpos_next    = npo_reg + 17'd2;
                                if (page_end > {1'b0, list_len_reg}) begin
                                    err_next = scmp_pkg::SC_OVERRUN;
                                end else begin
                                    npo_next = page_end;
                                end
                            end else if (plen_nz_reg && pos_reg == cpos_reg
                                         && code_reg == scmp_pkg::CACHING_PAGE) begin
                                saw_next    = 1'b1;
                                newbit_next = data_byte[2];
                            end
                        end
                        pos_next = pos_reg + 17'd1;
                        if (pos_next >= {1'b0, list_len_reg}) begin
                            phase_next = scmp_pkg::PH_IDLE;
                            out_load   = 1'b1;
                            if (err_next != scmp_pkg::SC_GOOD) begin
                                o_status = err_next;
                            end else if (saw_next && cache_present && newbit_next != wce_reg) begin
                                phase_next = scmp_pkg::PH_WAIT;
                                o_kind     = scmp_pkg::KIND_REQUEST;
                                o_req      = newbit_next;
                            end else begin
                                o_actual = list_len_reg;
                            end
                        end
                    end
                end
                scmp_pkg::OP_FEATURE: begin
                    if (phase_reg == scmp_pkg::PH_WAIT) begin
                        phase_next = scmp_pkg::PH_IDLE;
                        out_load   = 1'b1;
                        if (!feature_ok) begin
                            o_status = scmp_pkg::SC_MEDIUM;
                        end else begin
                            wce_next = newbit_reg;
                            o_actual = list_len_reg;
                        end
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.step) begin
            out_load = 1'b1;
            if (sts.stream_end) begin
                o_actual = {11'd0, n_reg};
            end else begin
                o_kind   = scmp_pkg::KIND_BYTE;
                o_byte   = s_byte;
                o_last   = 1'b0;
                idx_next = idx_reg + 5'd1;
            end
        end

        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg  <= 1'b0;
            phase_reg    <= scmp_pkg::PH_IDLE;
            err_reg      <= scmp_pkg::SC_GOOD;
            long_reg     <= 1'b0;
            list_len_reg <= 16'd0;
            pos_reg      <= 17'd0;
            desc_reg     <= 16'd0;
            npo_reg      <= 17'd0;
            code_reg     <= 6'd0;
            cpos_reg     <= 17'd0;
            plen_nz_reg  <= 1'b0;
            saw_reg      <= 1'b0;
            newbit_reg   <= 1'b0;
            wce_reg      <= 1'b0;
            n_reg        <= 5'd0;
            idx_reg      <= 5'd0;
            zero_reg     <= 1'b0;
            ten_reg      <= 1'b0;
        end else begin
            m_valid_reg  <= m_valid_next;
            phase_reg    <= phase_next;
            err_reg      <= err_next;
            long_reg     <= long_next;
            list_len_reg <= list_len_next;
            pos_reg      <= pos_next;
            desc_reg     <= desc_next;
            npo_reg      <= npo_next;
            code_reg     <= code_next;
            cpos_reg     <= cpos_next;
            plen_nz_reg  <= plen_nz_next;
            saw_reg      <= saw_next;
            newbit_reg   <= newbit_next;
            wce_reg      <= wce_next;
            n_reg        <= n_next;
            idx_reg      <= idx_next;
            zero_reg     <= zero_next;
            ten_reg      <= ten_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            kind_reg   <= o_kind;
            byte_reg   <= o_byte;
            last_reg   <= o_last;
            status_reg <= o_status;
            actual_reg <= o_actual;
            req_reg    <= o_req;
        end
    end

    assign m_valid       = m_valid_reg;
    assign kind          = kind_reg;
    assign response_byte = byte_reg;
    assign last          = last_reg;
    assign status        = status_reg;
    assign actual_length = actual_reg;
    assign cache_request = req_reg;

endmodule

/* sv/scsi_caching_mode_page_engine.sv */
// Caching mode page engine: keeps the write-cache-enable bit and serves mode sense and
// mode select for the caching page. Input transfers carry a command, a select list byte or
// a feature completion; each result transfer is a response byte, a completion or a
// set-features request, with tlast on the final result of an input. Items that give at
// most one result are accepted back to back while the result register drains.
// A sense that returns data streams n response bytes (at most 28): it is decoded when
// taken, then each byte and then the completion go out, paced by the output register.
// cache_present is at APB address 0 (bit 0).
module scsi_caching_mode_page_engine (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,  // is_ten_byte, page_sel[5:0], length[15:0], buffer_ok,
                                  // data_byte[7:0], feature_ok, zero fill
    input  logic [1:0]  s_tuser,  // operation
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,  // response_byte[7:0], status[2:0], actual_length[15:0],
                                  // cache_request, zero fill
    output logic [1:0]  m_tuser,  // kind
    output logic        m_tlast,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    scmp_pkg::cmd_t cmd;
    scmp_pkg::sts_t sts;

    logic        cache_present_reg;
    logic        cfg_write;
    logic [7:0]  response_byte;
    logic [2:0]  status;
    logic [15:0] actual_length;
    logic        cache_request;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready
                    && (paddr[2] == scmp_pkg::REG_CACHE_PRESENT);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cache_present_reg <= 1'b0;
        end else if (cfg_write) begin
            cache_present_reg <= pwdata[0];
        end
    end

    assign prdata = (paddr[2] == scmp_pkg::REG_CACHE_PRESENT) ? {31'd0, cache_present_reg}
                                                              : 32'd0;

    scmp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_tvalid),
        .s_ready (s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    scmp_dp u_dp (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .sts           (sts),
        .operation     (s_tuser),
        .is_ten_byte   (s_tdata[0]),
        .page_sel      (s_tdata[6:1]),
        .length        (s_tdata[22:7]),
        .buffer_ok     (s_tdata[23]),
        .data_byte     (s_tdata[31:24]),
        .feature_ok    (s_tdata[32]),
        .cache_present (cache_present_reg),
        .m_valid       (m_tvalid),
        .m_ready       (m_tready),
        .kind          (m_tuser),
        .response_byte (response_byte),
        .last          (m_tlast),
        .status        (status),
        .actual_length (actual_length),
        .cache_request (cache_request)
    );

    assign m_tdata = {4'd0, cache_request, actual_length, status, response_byte};

    a_last_marks_non_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tlast == (m_tuser != scmp_pkg::KIND_BYTE)))
        else $error("tlast does not match result kind");

    a_stream_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.streaming |-> !s_tready)
        else $error("input taken during sense stream");

    a_stream_starts: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_tvalid && s_tready && sts.start_stream) |=> cmd.streaming)
        else $error("sense stream did not start");

    a_request_clean: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && m_tuser == scmp_pkg::KIND_REQUEST) |-> (status == scmp_pkg::SC_GOOD
            && actual_length == 16'd0 && response_byte == 8'd0))
        else $error("set-features request carries stray fields");

endmodule
